FILE: design/ucd_pkg.sv
package ucd_pkg;

  // Field widths of the words at the ports
  localparam int UNIX_W  = 64;
  localparam int YEAR_W  = 40;
  localparam int MONTH_W = 4;
  localparam int DOM_W   = 5;
  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int SEC_W   = 6;
  localparam int WDAY_W  = 3;

  // 86400 = 675 << 7: the low 7 bits of the time pass straight into the second of day
  localparam int SEC_LO_W   = 7;
  localparam int DAY_ODD    = 675;
  localparam int DAY_REM_W  = 10;
  localparam int DIV1_W     = 58;
  localparam int DAY_BIAS_SH = 47;
  // Bias that makes the day division operate on a non-negative dividend
  localparam logic [DIV1_W-1:0] DIV1_BIAS = DIV1_W'(64'd675 << DAY_BIAS_SH);

  localparam int SOD_W        = 17;
  localparam int DOE_W        = 18;
  localparam int DAYS_PER_ERA = 146097;
  localparam int DIV2_W       = 48;
  localparam int ERA_BIAS_SH  = 30;
  // days -> era-biased day count: + 719468 (shift to 0000-03-01), + era bias,
  // - day bias left in the first quotient
  localparam logic [DIV2_W-1:0] DIV2_BIAS =
    DIV2_W'(64'd146097 * (64'd1 << ERA_BIAS_SH) + 64'd719468 - (64'd1 << DAY_BIAS_SH));
  // 400 * era bias, removed from 400 * biased era quotient
  localparam logic [YEAR_W-1:0] ERA400_BIAS = YEAR_W'(64'd400 << ERA_BIAS_SH);

  localparam int QUAD_DAYS = 1460;
  localparam int CENT_DAYS = 36524;
  localparam int ERA_LAST  = 146096;

  // Reciprocals for exact division by constants over the value ranges used here
  localparam int RCP_W   = 24;
  localparam int SH_HI   = 32;
  localparam int SH_LO   = 24;
  localparam logic [RCP_W-1:0] RCP_1460 = RCP_W'(((64'd1 << SH_HI) + 64'd1459) / 64'd1460);
  localparam logic [RCP_W-1:0] RCP_3600 = RCP_W'(((64'd1 << SH_HI) + 64'd3599) / 64'd3600);
  localparam logic [RCP_W-1:0] RCP_365  = RCP_W'(((64'd1 << SH_HI) + 64'd364) / 64'd365);
  localparam logic [RCP_W-1:0] RCP_7    = RCP_W'(((64'd1 << SH_LO) + 64'd6) / 64'd7);
  localparam logic [RCP_W-1:0] RCP_60   = RCP_W'(((64'd1 << SH_LO) + 64'd59) / 64'd60);
  localparam logic [RCP_W-1:0] RCP_100  = RCP_W'(((64'd1 << SH_LO) + 64'd99) / 64'd100);
  localparam logic [RCP_W-1:0] RCP_153  = RCP_W'(((64'd1 << SH_LO) + 64'd152) / 64'd153);

  typedef struct packed {
    logic signed [YEAR_W-1:0] year;
    logic [MONTH_W-1:0]       month;
    logic [DOM_W-1:0]         day_of_month;
    logic [HOUR_W-1:0]        hour;
    logic [MIN_W-1:0]         minute;
    logic [SEC_W-1:0]         second;
    logic [WDAY_W-1:0]        weekday;
  } civil_t;

  // First day of each March-based month within the year, (153*mp+2)/5
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] v;
    case (mp)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd31;
      4'd2:    v = 9'd61;
      4'd3:    v = 9'd92;
      4'd4:    v = 9'd122;
      4'd5:    v = 9'd153;
      4'd6:    v = 9'd184;
      4'd7:    v = 9'd214;
      4'd8:    v = 9'd245;
      4'd9:    v = 9'd275;
      4'd10:   v = 9'd306;
      4'd11:   v = 9'd337;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: design/ucd_in_if.sv
interface ucd_in_if;
  import ucd_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [UNIX_W-1:0] unix_seconds;

  modport source (output valid, output unix_seconds, input ready);
  modport sink   (input valid, input unix_seconds, output ready);
endinterface

FILE: design/ucd_out_if.sv
interface ucd_out_if;
  import ucd_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [YEAR_W-1:0] year;
  logic [MONTH_W-1:0]       month;
  logic [DOM_W-1:0]         day_of_month;
  logic [HOUR_W-1:0]        hour;
  logic [MIN_W-1:0]         minute;
  logic [SEC_W-1:0]         second;
  logic [WDAY_W-1:0]        weekday;

  modport source (output valid, output year, output month, output day_of_month,
                  output hour, output minute, output second, output weekday,
                  input ready);
  modport sink   (input valid, input year, input month, input day_of_month,
                  input hour, input minute, input second, input weekday,
                  output ready);
endinterface

FILE: design/ucd_longdiv.sv
// Pipelined radix-16 long division of an unsigned value by a constant.
// One quotient digit per stage; the dividend shifts out as quotient shifts in.
module ucd_longdiv #(
  parameter int DIVIDEND_W = 58,
  parameter int DIVISOR    = 675,
  parameter int SIDE_W     = 7,
  localparam int REM_W     = $clog2(DIVISOR)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [SIDE_W-1:0]     in_side,
  output logic                  out_valid,
  output logic [DIVIDEND_W-1:0] quotient,
  output logic [REM_W-1:0]      remainder,
  output logic [SIDE_W-1:0]     out_side
);

  localparam int DIGIT_W = 4;
  localparam int RADIX   = 1 << DIGIT_W;
  localparam int DIGITS  = (DIVIDEND_W + DIGIT_W - 1) / DIGIT_W;
  localparam int PAD_W   = DIGITS * DIGIT_W;
  localparam int X_W     = REM_W + DIGIT_W;

  logic              vld  [DIGITS];
  logic [PAD_W-1:0]  work [DIGITS];
  logic [REM_W-1:0]  rem  [DIGITS];
  logic [SIDE_W-1:0] side [DIGITS];

  for (genvar k = 0; k < DIGITS; k++) begin : g_stage
    logic               v_in;
    logic [PAD_W-1:0]   w_in;
    logic [REM_W-1:0]   r_in;
    logic [SIDE_W-1:0]  s_in;
    logic [X_W-1:0]     x;
    logic [X_W-1:0]     sub;
    logic [DIGIT_W-1:0] digit;

    if (k == 0) begin : g_first
      assign v_in = in_valid;
      assign w_in = PAD_W'(dividend);
      assign r_in = '0;
      assign s_in = in_side;
    end else begin : g_next
      assign v_in = vld[k-1];
      assign w_in = work[k-1];
      assign r_in = rem[k-1];
      assign s_in = side[k-1];
    end

    // parallel compares against the digit multiples of the divisor
    always_comb begin
      x     = {r_in, w_in[PAD_W-1 -: DIGIT_W]};
      digit = '0;
      sub   = '0;
      for (int j = 1; j < RADIX; j++) begin
        if (x >= X_W'(j * DIVISOR)) begin
          digit = DIGIT_W'(j);
          sub   = X_W'(j * DIVISOR);
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        work[k] <= {w_in[PAD_W-DIGIT_W-1:0], digit};
        rem[k]  <= REM_W'(x - sub);
        side[k] <= s_in;
      end
    end
  end

  assign out_valid = vld[DIGITS-1];
  assign quotient  = work[DIGITS-1][DIVIDEND_W-1:0];
  assign remainder = rem[DIGITS-1];
  assign out_side  = side[DIGITS-1];

endmodule

FILE: design/ucd_civil.sv
// Day of era and second of day to calendar fields, seven stages.
module ucd_civil (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [ucd_pkg::YEAR_W-1:0] era_q,
  input  logic [ucd_pkg::DOE_W-1:0]  doe,
  input  logic [ucd_pkg::SOD_W-1:0]  sod,
  output logic                       out_valid,
  output ucd_pkg::civil_t            res
);
  import ucd_pkg::*;

  logic [6:0] vld;

  // stage 1
  logic [DOE_W-1:0]  c1_doe;
  logic [SOD_W-1:0]  c1_sod;
  logic [YEAR_W-1:0] c1_era400;
  logic [6:0]        c1_d1460;
  logic [2:0]        c1_dcen;
  logic              c1_dera;
  logic [14:0]       c1_wq;
  logic [HOUR_W-1:0] c1_hour;
  // stage 2
  logic [DOE_W-1:0]  c2_doe;
  logic [DOE_W-1:0]  c2_num;
  logic [WDAY_W-1:0] c2_wday;
  logic [11:0]       c2_remh;
  logic [YEAR_W-1:0] c2_era400;
  logic [HOUR_W-1:0] c2_hour;
  // stage 3
  logic [DOE_W-1:0]  c3_doe;
  logic [8:0]        c3_yoe;
  logic [MIN_W-1:0]  c3_min;
  logic [11:0]       c3_remh;
  logic [YEAR_W-1:0] c3_era400;
  logic [HOUR_W-1:0] c3_hour;
  logic [WDAY_W-1:0] c3_wday;
  // stage 4
  logic [DOE_W-1:0]  c4_doe;
  logic [8:0]        c4_yoe;
  logic [1:0]        c4_y100;
  logic [SEC_W-1:0]  c4_sec;
  logic [YEAR_W-1:0] c4_ybase;
  logic [MIN_W-1:0]  c4_min;
  logic [HOUR_W-1:0] c4_hour;
  logic [WDAY_W-1:0] c4_wday;
  // stage 5
  logic [8:0]        c5_doy;
  logic [YEAR_W-1:0] c5_ybase;
  logic [SEC_W-1:0]  c5_sec;
  logic [MIN_W-1:0]  c5_min;
  logic [HOUR_W-1:0] c5_hour;
  logic [WDAY_W-1:0] c5_wday;
  // stage 6
  logic [3:0]        c6_mp;
  logic [8:0]        c6_doy;
  logic [YEAR_W-1:0] c6_ybase;
  logic [SEC_W-1:0]  c6_sec;
  logic [MIN_W-1:0]  c6_min;
  logic [HOUR_W-1:0] c6_hour;
  logic [WDAY_W-1:0] c6_wday;

  // combinational terms
  logic [YEAR_W-1:0] era400;
  logic [41:0]       p_1460;
  logic [41:0]       p_7;
  logic [40:0]       p_3600;
  logic [2:0]        dcen;
  logic [41:0]       p_365;
  logic [35:0]       p_60;
  logic [32:0]       p_100;
  logic [10:0]       mp_num;
  logic [34:0]       p_153;

  always_comb begin
    era400 = (era_q << 8) + (era_q << 7) + (era_q << 4) - ERA400_BIAS;
    p_1460 = 42'(doe) * 42'(RCP_1460);
    p_7    = 42'(doe + DOE_W'(3)) * 42'(RCP_7);
    p_3600 = 41'(sod) * 41'(RCP_3600);
    dcen   = '0;
    for (int k = 1; k <= 4; k++) begin
      if (doe >= DOE_W'(k * CENT_DAYS)) begin
        dcen = 3'(k);
      end
    end
    p_365  = 42'(c2_num) * 42'(RCP_365);
    p_60   = 36'(c2_remh) * 36'(RCP_60);
    p_100  = 33'(c3_yoe) * 33'(RCP_100);
    mp_num = 11'(c5_doy) * 11'd5 + 11'd2;
    p_153  = 35'(mp_num) * 35'(RCP_153);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[5:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // 1: quotient estimates by reciprocal, century and era end by compare
      c1_doe    <= doe;
      c1_sod    <= sod;
      c1_era400 <= era400;
      c1_d1460  <= p_1460[SH_HI +: 7];
      c1_dcen   <= dcen;
      c1_dera   <= (doe >= DOE_W'(ERA_LAST));
      c1_wq     <= p_7[SH_LO +: 15];
      c1_hour   <= p_3600[SH_HI +: HOUR_W];

      // 2: leap-day corrected count, weekday, seconds in hour
      c2_doe    <= c1_doe;
      c2_num    <= c1_doe - DOE_W'(c1_d1460) + DOE_W'(c1_dcen) - DOE_W'(c1_dera);
      c2_wday   <= WDAY_W'(c1_doe + DOE_W'(3) - DOE_W'(c1_wq) * DOE_W'(7));
      c2_remh   <= 12'(c1_sod - SOD_W'(c1_hour) * SOD_W'(3600));
      c2_era400 <= c1_era400;
      c2_hour   <= c1_hour;

      // 3: year of era, minute
      c3_doe    <= c2_doe;
      c3_yoe    <= p_365[SH_HI +: 9];
      c3_min    <= p_60[SH_LO +: MIN_W];
      c3_remh   <= c2_remh;
      c3_era400 <= c2_era400;
      c3_hour   <= c2_hour;
      c3_wday   <= c2_wday;

      // 4: centuries in era, second, March-based year
      c4_doe    <= c3_doe;
      c4_yoe    <= c3_yoe;
      c4_y100   <= p_100[SH_LO +: 2];
      c4_sec    <= SEC_W'(c3_remh - 12'(c3_min) * 12'd60);
      c4_ybase  <= c3_era400 + YEAR_W'(c3_yoe);
      c4_min    <= c3_min;
      c4_hour   <= c3_hour;
      c4_wday   <= c3_wday;

      // 5: day of March-based year
      c5_doy    <= 9'(c4_doe - (DOE_W'(c4_yoe) * DOE_W'(365) + DOE_W'(c4_yoe[8:2])
                                - DOE_W'(c4_y100)));
      c5_ybase  <= c4_ybase;
      c5_sec    <= c4_sec;
      c5_min    <= c4_min;
      c5_hour   <= c4_hour;
      c5_wday   <= c4_wday;

      // 6: March-based month
      c6_mp     <= p_153[SH_LO +: 4];
      c6_doy    <= c5_doy;
      c6_ybase  <= c5_ybase;
      c6_sec    <= c5_sec;
      c6_min    <= c5_min;
      c6_hour   <= c5_hour;
      c6_wday   <= c5_wday;

      // 7: Jan/Feb belong to the next civil year
      res.month        <= (c6_mp < 4'd10) ? c6_mp + 4'd3 : c6_mp - 4'd9;
      res.day_of_month <= DOM_W'(c6_doy - month_start(c6_mp) + 9'd1);
      res.year         <= $signed(c6_ybase + YEAR_W'(c6_mp >= 4'd10));
      res.hour         <= c6_hour;
      res.minute       <= c6_min;
      res.second       <= c6_sec;
      res.weekday      <= c6_wday;
    end
  end

  assign out_valid = vld[6];

endmodule

FILE: design/unix_seconds_to_civil_date_unit.sv
// A word passes the input register, the 15-stage day divider, a middle register, the
// 12-stage era divider, the 7-stage calendar pipeline and the output register; one word
// per cycle while the skid buffer is empty, and the whole pipeline holds while it is full.
// Reset (rst, synchronous): clears every valid bit, so the pipeline, the output
// register and the skid buffer come up empty; data registers are not reset.
module unix_seconds_to_civil_date_unit (
  input  logic       clk,
  input  logic       rst,
  ucd_in_if.sink     stamp,
  ucd_out_if.source  civil
);
  import ucd_pkg::*;

  // Whole pipeline steps together; it only holds when the skid buffer is full,
  // so ready is a register output and never depends on the output's ready.
  logic en;

  // Input register: floor(t / 128) with bias, low 7 bits kept for second of day
  logic                prep_vld;
  logic [DIV1_W-1:0]   prep_u;
  logic [SEC_LO_W-1:0] prep_lo;

  // Day divider (divide by 675)
  logic                 d1_vld;
  logic [DIV1_W-1:0]    d1_q;
  logic [DAY_REM_W-1:0] d1_r;
  logic [SEC_LO_W-1:0]  d1_lo;

  // Between dividers: second of day, era-biased day count
  logic              mid_vld;
  logic [DIV2_W-1:0] mid_u;
  logic [SOD_W-1:0]  mid_sod;

  // Era divider (divide by 146097)
  logic              d2_vld;
  logic [DIV2_W-1:0] d2_q;
  logic [DOE_W-1:0]  d2_r;
  logic [SOD_W-1:0]  d2_sod;

  // Calendar pipeline tail
  logic   tail_vld;
  civil_t tail;

  // Output register and skid buffer
  logic   o_vld;
  civil_t o_res;
  logic   s_vld;
  civil_t s_res;

  assign en          = !s_vld;
  assign stamp.ready = en;

  // Arithmetic shift by 7 divides by 128 rounding down; adding 675 << 47 keeps the
  // dividend positive, and the same bias falls out of the quotient as 2^47 days.
  always_ff @(posedge clk) begin
    if (rst) begin
      prep_vld <= 1'b0;
    end else if (en) begin
      prep_vld <= stamp.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prep_u  <= {stamp.unix_seconds[UNIX_W-1], stamp.unix_seconds[UNIX_W-1:SEC_LO_W]}
                 + DIV1_BIAS;
      prep_lo <= stamp.unix_seconds[SEC_LO_W-1:0];
    end
  end

  ucd_longdiv #(
    .DIVIDEND_W (DIV1_W),
    .DIVISOR    (DAY_ODD),
    .SIDE_W     (SEC_LO_W)
  ) u_div_day (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (prep_vld),
    .dividend  (prep_u),
    .in_side   (prep_lo),
    .out_valid (d1_vld),
    .quotient  (d1_q),
    .remainder (d1_r),
    .out_side  (d1_lo)
  );

  // Second of day = remainder * 128 + low bits, a plain concatenation.
  // Day count moves to the March-based calendar with a positive era bias; the
  // result stays below 2^48 for every input, so the upper quotient bits drop.
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_vld <= 1'b0;
    end else if (en) begin
      mid_vld <= d1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mid_u   <= d1_q[DIV2_W-1:0] + DIV2_BIAS;
      mid_sod <= {d1_r, d1_lo};
    end
  end

  ucd_longdiv #(
    .DIVIDEND_W (DIV2_W),
    .DIVISOR    (DAYS_PER_ERA),
    .SIDE_W     (SOD_W)
  ) u_div_era (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (mid_vld),
    .dividend  (mid_u),
    .in_side   (mid_sod),
    .out_valid (d2_vld),
    .quotient  (d2_q),
    .remainder (d2_r),
    .out_side  (d2_sod)
  );

  // Era quotient is taken modulo 2^40; the year fits 40 bits, so the wrap is exact.
  ucd_civil u_civil (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d2_vld),
    .era_q     (d2_q[YEAR_W-1:0]),
    .doe       (d2_r),
    .sod       (d2_sod),
    .out_valid (tail_vld),
    .res       (tail)
  );

  // Output register plus one-entry skid: a word leaving the tail while the output
  // is stalled parks in the skid, and the pipeline holds until it drains.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
      s_vld <= 1'b0;
    end else if (s_vld) begin
      if (civil.ready) begin
        s_vld <= 1'b0;
      end
    end else if (!o_vld || civil.ready) begin
      o_vld <= tail_vld;
    end else if (tail_vld) begin
      s_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s_vld) begin
      if (civil.ready) begin
        o_res <= s_res;
      end
    end else if (!o_vld || civil.ready) begin
      o_res <= tail;
    end else begin
      s_res <= tail;
    end
  end

  assign civil.valid        = o_vld;
  assign civil.year         = o_res.year;
  assign civil.month        = o_res.month;
  assign civil.day_of_month = o_res.day_of_month;
  assign civil.hour         = o_res.hour;
  assign civil.minute       = o_res.minute;
  assign civil.second       = o_res.second;
  assign civil.weekday      = o_res.weekday;

  // A parked word always has an output word ahead of it.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    s_vld |-> o_vld)
    else $error("skid buffer holds a word while output register is empty");

  // A tail word meeting a stalled output must land in the skid, unchanged.
  a_skid_capture: assert property (@(posedge clk) disable iff (rst)
    (!s_vld && o_vld && !civil.ready && tail_vld) |=> (s_vld && s_res == $past(tail)))
    else $error("tail word lost on output stall");

  // Every delivered word carries in-range calendar and clock fields.
  a_field_range: assert property (@(posedge clk) disable iff (rst)
    o_vld |-> (o_res.month >= 4'd1 && o_res.month <= 4'd12 &&
               o_res.day_of_month >= 5'd1 && o_res.hour <= 5'd23 &&
               o_res.minute <= 6'd59 && o_res.second <= 6'd59 &&
               o_res.weekday <= 3'd6))
    else $error("result field out of range");

endmodule
